### sv/ipte_pkg.sv
package ipte_pkg;

  // Fixed field widths of the configuration registers and the running sum.
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned DIST_W    = 20;
  localparam int unsigned HOLD_W    = 32;
  localparam int unsigned MASK_W    = 24;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned HOURS     = 24;

  // One hour is 3600000 ms = 128 * 28125, so the hour of the day is
  // floor(((ts >> 7) mod 675000) / 28125).
  localparam int unsigned MS_SHIFT    = 7;
  localparam int unsigned HOUR_TICKS  = 28125;
  localparam int unsigned DAY_TICKS   = 675000;
  localparam int unsigned DAY_W       = 20;
  localparam int unsigned RECIP_SHIFT = 40;
  localparam int unsigned RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] DAY_RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / DAY_TICKS);

  // Side pipeline stages that follow the input register.
  localparam int unsigned PIPE_N = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_IMPULSE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULLBACK_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_PROFIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LOSS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SESSION_MASK = 3'd5;

  localparam logic [DIST_W-1:0] RST_MIN_IMPULSE  = 20'd1200;
  localparam logic [DIST_W-1:0] RST_PULLBACK_MAX = 20'd400;
  localparam logic [DIST_W-1:0] RST_TAKE_PROFIT  = 20'd1000;
  localparam logic [DIST_W-1:0] RST_STOP_LOSS    = 20'd500;
  localparam logic [HOLD_W-1:0] RST_MAX_HOLD     = 32'd1800;
  localparam logic [MASK_W-1:0] RST_SESSION_MASK = 24'd257920;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 3'd0,
    EV_ENTER_LONG  = 3'd1,
    EV_ENTER_SHORT = 3'd2,
    EV_EXIT_LONG   = 3'd3,
    EV_EXIT_SHORT  = 3'd4
  } event_t;

  typedef struct packed {
    logic [DIST_W-1:0] min_impulse;
    logic [DIST_W-1:0] pullback_max;
    logic [DIST_W-1:0] take_profit;
    logic [DIST_W-1:0] stop_loss;
    logic [HOLD_W-1:0] max_hold;
    logic [MASK_W-1:0] session_mask;
  } cfg_t;

  // load[j] moves side stage j+1; first_take marks a real tick leaving the
  // input register, which is when the running mean takes it in.
  typedef struct packed {
    logic [PIPE_N-1:0] load;
    logic              first_take;
  } pipe_ctl_t;

  // 2^(8*idx) mod DAY_TICKS, by doubling with a conditional subtract.
  function automatic logic [DAY_W-1:0] chunk_res(input int unsigned idx);
    logic [DAY_W:0] r;
    r = (DAY_W+1)'(1);
    for (int unsigned k = 0; k < 8 * idx; k++) begin
      r = {r[DAY_W-1:0], 1'b0};
      if (r >= (DAY_W+1)'(DAY_TICKS)) begin
        r = r - (DAY_W+1)'(DAY_TICKS);
      end
    end
    return r[DAY_W-1:0];
  endfunction

endpackage

### sv/ipte_hour.sv
module ipte_hour #(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                         clk,
  input  ipte_pkg::pipe_ctl_t          ctl,
  input  logic [TIME_BITS-1:0]         ts,
  output logic [ipte_pkg::HOUR_W-1:0]  hour
);

  localparam int unsigned TB   = TIME_BITS - ipte_pkg::MS_SHIFT;
  localparam int unsigned NCH  = (TB + 7) / 8;
  localparam int unsigned PADW = NCH * 8;
  // Up to eight chunks of 255 times a residue below 675000 fit in 31 bits.
  localparam int unsigned VW   = 31;
  localparam int unsigned QW   = 12;
  localparam int unsigned PW   = VW + ipte_pkg::RECIP_W;
  localparam int unsigned RW   = ipte_pkg::DAY_W + 1;

  logic [PADW-1:0]             t_pad;
  logic [VW-1:0]               part [NCH];
  logic [VW-1:0]               acc;
  logic [PW-1:0]               prod;
  logic [VW-1:0]               rem_full;
  logic [ipte_pkg::DAY_W-1:0]  day_pos;
  logic [ipte_pkg::HOUR_W-1:0] hour_nxt;

  logic [VW-1:0]               v1_r;
  logic [VW-1:0]               v2_r;
  logic [QW-1:0]               q2_r;
  logic [RW-1:0]               rr3_r;
  logic [ipte_pkg::HOUR_W-1:0] hour4_r;

  assign t_pad = PADW'(ts[TIME_BITS-1:ipte_pkg::MS_SHIFT]);

  // Each byte of the 128 ms count is folded in with its weight mod one day.
  for (genvar g = 0; g < NCH; g++) begin : g_chunk
    localparam logic [ipte_pkg::DAY_W-1:0] RES = ipte_pkg::chunk_res(g);
    assign part[g] = VW'(t_pad[g*8 +: 8]) * VW'(RES);
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NCH; i++) begin
      acc = acc + part[i];
    end
  end

  // The reciprocal estimate is exact or one short of the true quotient.
  assign prod     = PW'(v1_r) * PW'(ipte_pkg::DAY_RECIP);
  assign rem_full = v2_r - VW'(q2_r) * VW'(ipte_pkg::DAY_TICKS);

  always_comb begin
    if (rr3_r >= RW'(ipte_pkg::DAY_TICKS)) begin
      day_pos = ipte_pkg::DAY_W'(rr3_r - RW'(ipte_pkg::DAY_TICKS));
    end else begin
      day_pos = rr3_r[ipte_pkg::DAY_W-1:0];
    end
    hour_nxt = '0;
    for (int k = 1; k < ipte_pkg::HOURS; k++) begin
      if (day_pos >= ipte_pkg::DAY_W'(k * ipte_pkg::HOUR_TICKS)) begin
        hour_nxt = ipte_pkg::HOUR_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      v1_r <= acc;
    end
    if (ctl.load[1]) begin
      v2_r <= v1_r;
      q2_r <= prod[ipte_pkg::RECIP_SHIFT +: QW];
    end
    if (ctl.load[2]) begin
      rr3_r <= rem_full[RW-1:0];
    end
    if (ctl.load[3]) begin
      hour4_r <= hour_nxt;
    end
  end

  assign hour = hour4_r;

endmodule

### sv/ipte_mean.sv
module ipte_mean #(
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipte_pkg::pipe_ctl_t   ctl,
  input  logic [PRICE_BITS:0]   mid,
  output logic                  above,
  output logic                  below
);

  localparam int unsigned MW = PRICE_BITS + 1;
  localparam int unsigned SW = ipte_pkg::SUM_W;
  localparam int unsigned SX = SW + 1;
  localparam int unsigned PW = MW + COUNT_BITS;
  localparam int unsigned CW = (PW > SW) ? PW : SW;

  logic [SW-1:0]         sum_r;
  logic [SW-1:0]         sum_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [SX-1:0]         sum_ext;

  logic [MW-1:0]         m1_r;
  logic [SW-1:0]         sum1_r;
  logic [COUNT_BITS-1:0] cnt1_r;
  logic [PW-1:0]         prod2_r;
  logic [SW-1:0]         sum2_r;
  logic                  above3_r;
  logic                  below3_r;
  logic                  above4_r;
  logic                  below4_r;

  // The sum and count freeze together once either would overflow.
  always_comb begin
    sum_ext = {1'b0, sum_r} + SX'(mid);
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (cnt_r != '1 && !sum_ext[SW]) begin
      sum_nxt = sum_ext[SW-1:0];
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (ctl.first_take) begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // The mean is compared as mid * count against the sum, both exact.
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      m1_r   <= mid;
      sum1_r <= sum_nxt;
      cnt1_r <= cnt_nxt;
    end
    if (ctl.load[1]) begin
      prod2_r <= PW'(m1_r) * PW'(cnt1_r);
      sum2_r  <= sum1_r;
    end
    if (ctl.load[2]) begin
      above3_r <= CW'(prod2_r) > CW'(sum2_r);
      below3_r <= CW'(prod2_r) < CW'(sum2_r);
    end
    if (ctl.load[3]) begin
      above4_r <= above3_r;
      below4_r <= below3_r;
    end
  end

  assign above = above4_r;
  assign below = below4_r;

endmodule

### sv/ipte_trade.sv
module ipte_trade #(
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [TIME_BITS-1:0]          ts,
  input  logic [PRICE_BITS-1:0]         ask,
  input  logic [PRICE_BITS-1:0]         bid,
  input  logic                          above,
  input  logic                          below,
  input  logic [ipte_pkg::HOUR_W-1:0]   hour,
  input  ipte_pkg::cfg_t                cfg,
  output logic [ipte_pkg::EVENT_W-1:0]  event_res,
  output logic [PRICE_BITS-1:0]         trade_price,
  output logic signed [PRICE_BITS:0]    trade_pnl,
  output logic                          in_position,
  output logic                          session_open
);

  localparam int unsigned MW = PRICE_BITS + 1;
  localparam int unsigned DW = ipte_pkg::DIST_W;
  // Range compares against doubled distances; exit compares add a distance.
  localparam int unsigned CW = ((MW > DW) ? MW : DW) + 1;
  localparam int unsigned EW = ((PRICE_BITS > DW) ? PRICE_BITS : DW) + 1;

  logic                  pos_r, pos_nxt;
  logic                  side_r, side_nxt;
  logic                  rv_r;
  logic [MW-1:0]         rh_r, rh_nxt;
  logic [MW-1:0]         rl_r, rl_nxt;
  logic [PRICE_BITS-1:0] entry_r, entry_nxt;
  logic [TIME_BITS-1:0]  etime_r, etime_nxt;

  ipte_pkg::event_t      ev_r, ev_nxt;
  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic [MW-1:0]         pnl_r, pnl_nxt;
  logic                  inpos_r;
  logic                  sess_r;

  logic [MW-1:0]         mid;
  logic [MW-1:0]         rng_hi;
  logic [MW-1:0]         rng_lo;
  logic                  sess;
  logic                  impulse_ok;
  logic                  long_ok;
  logic                  short_ok;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  timeout;
  logic [EW-1:0]         e_x, bid_x, ask_x, tp_x, sl_x;
  logic                  long_hit;
  logic                  short_hit;

  assign mid  = MW'(ask) + MW'(bid);
  assign sess = cfg.session_mask[hour];

  // The range always widens first; an entry then collapses it to the mid.
  always_comb begin
    if (!rv_r) begin
      rng_hi = mid;
      rng_lo = mid;
    end else begin
      rng_hi = (mid > rh_r) ? mid : rh_r;
      rng_lo = (mid < rl_r) ? mid : rl_r;
    end
  end

  assign impulse_ok = CW'(rng_hi - rng_lo) >= (CW'(cfg.min_impulse) << 1);
  assign long_ok    = above && (CW'(rng_hi - mid) <= (CW'(cfg.pullback_max) << 1));
  assign short_ok   = below && (CW'(mid - rng_lo) <= (CW'(cfg.pullback_max) << 1));

  assign elapsed = ts - etime_r;
  assign timeout = elapsed > TIME_BITS'(cfg.max_hold);

  assign e_x   = EW'(entry_r);
  assign bid_x = EW'(bid);
  assign ask_x = EW'(ask);
  assign tp_x  = EW'(cfg.take_profit);
  assign sl_x  = EW'(cfg.stop_loss);

  assign long_hit  = (bid_x >= e_x + tp_x) || (bid_x + sl_x <= e_x) || timeout;
  assign short_hit = (ask_x + tp_x <= e_x) || (ask_x >= e_x + sl_x) || timeout;

  always_comb begin
    rh_nxt    = rng_hi;
    rl_nxt    = rng_lo;
    pos_nxt   = pos_r;
    side_nxt  = side_r;
    entry_nxt = entry_r;
    etime_nxt = etime_r;
    ev_nxt    = ipte_pkg::EV_NONE;
    price_nxt = '0;
    pnl_nxt   = '0;
    if (sess) begin
      if (!pos_r) begin
        if (impulse_ok && long_ok) begin
          pos_nxt   = 1'b1;
          side_nxt  = 1'b1;
          entry_nxt = ask;
          etime_nxt = ts;
          ev_nxt    = ipte_pkg::EV_ENTER_LONG;
          price_nxt = ask;
          rh_nxt    = mid;
          rl_nxt    = mid;
        end else if (impulse_ok && short_ok) begin
          pos_nxt   = 1'b1;
          side_nxt  = 1'b0;
          entry_nxt = bid;
          etime_nxt = ts;
          ev_nxt    = ipte_pkg::EV_ENTER_SHORT;
          price_nxt = bid;
          rh_nxt    = mid;
          rl_nxt    = mid;
        end
      end else if (side_r) begin
        if (long_hit) begin
          pos_nxt   = 1'b0;
          ev_nxt    = ipte_pkg::EV_EXIT_LONG;
          price_nxt = bid;
          pnl_nxt   = {1'b0, bid} - {1'b0, entry_r};
        end
      end else begin
        if (short_hit) begin
          pos_nxt   = 1'b0;
          ev_nxt    = ipte_pkg::EV_EXIT_SHORT;
          price_nxt = ask;
          pnl_nxt   = {1'b0, entry_r} - {1'b0, ask};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 1'b0;
      rv_r  <= 1'b0;
    end else if (take) begin
      pos_r <= pos_nxt;
      rv_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      side_r  <= side_nxt;
      rh_r    <= rh_nxt;
      rl_r    <= rl_nxt;
      entry_r <= entry_nxt;
      etime_r <= etime_nxt;
      ev_r    <= ev_nxt;
      price_r <= price_nxt;
      pnl_r   <= pnl_nxt;
      inpos_r <= pos_nxt;
      sess_r  <= sess;
    end
  end

  assign event_res    = ev_r;
  assign trade_price  = price_r;
  assign trade_pnl    = pnl_r;
  assign in_position  = inpos_r;
  assign session_open = sess_r;

endmodule

### sv/impulse_pullback_trade_engine_unit.sv
// Channel    Direction  Ports                  Contents (lowest bits first)
// in_        slave      tvalid tready tdata    timestamp, ask_price, bid_price
// out_       master     tvalid tready tdata    trade_price, trade_pnl, in_position,
//                                 tuser        session_open / tuser: event_res
// cfg_       write      we index wdata         register index and value
//
// One tick is accepted per cycle unless the output stalls; each tick passes through
// an input register, four side stages (running mean, product compare, hour of
// day) and the trading decision, which updates position and range together.
// Each stage moves whenever it is empty or the stage after it moves, so bubbles
// close up and a waiting result does not stop new transfers until the stages fill.
// Reset (rst_n low, synchronous) empties the pipeline, clears the mean, range
// and position, and loads the default register values.
module impulse_pullback_trade_engine_unit #(
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned TIME_BITS  = 48,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // timestamp, ask_price, bid_price
  input  logic [((TIME_BITS+2*PRICE_BITS+7)/8)*8-1:0]   in_tdata,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // trade_price, trade_pnl, in_position, session_open
  output logic [((2*PRICE_BITS+3+7)/8)*8-1:0]           out_tdata,
  // event_res
  output logic [ipte_pkg::EVENT_W-1:0]                  out_tuser,
  input  logic                                          cfg_we,
  input  logic [ipte_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [ipte_pkg::CFG_W-1:0]                    cfg_wdata
);

  localparam int unsigned NST   = 5;
  localparam int unsigned OUT_W = ((2*PRICE_BITS+3+7)/8)*8;

  logic [NST:0]            adv;
  logic [NST-1:0]          vld_r;
  logic                    out_vld_r;
  logic [TIME_BITS-1:0]    ts_r  [NST];
  logic [PRICE_BITS-1:0]   ask_r [NST];
  logic [PRICE_BITS-1:0]   bid_r [NST];
  logic [PRICE_BITS:0]     mid0;

  ipte_pkg::cfg_t          cfg_r;
  ipte_pkg::pipe_ctl_t     ctl;

  logic                    above;
  logic                    below;
  logic [ipte_pkg::HOUR_W-1:0]  hour;
  logic [ipte_pkg::EVENT_W-1:0] event_res;
  logic [PRICE_BITS-1:0]   trade_price;
  logic signed [PRICE_BITS:0] trade_pnl;
  logic                    in_position;
  logic                    session_open;

  always_comb begin
    adv[NST] = !out_vld_r || out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready      = adv[0];
  assign ctl.load       = adv[ipte_pkg::PIPE_N:1];
  assign ctl.first_take = adv[1] && vld_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (adv[NST]) begin
        out_vld_r <= vld_r[NST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ts_r[0]  <= in_tdata[TIME_BITS-1:0];
      ask_r[0] <= in_tdata[TIME_BITS +: PRICE_BITS];
      bid_r[0] <= in_tdata[TIME_BITS+PRICE_BITS +: PRICE_BITS];
    end
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) begin
        ts_r[k]  <= ts_r[k-1];
        ask_r[k] <= ask_r[k-1];
        bid_r[k] <= bid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_impulse  <= ipte_pkg::RST_MIN_IMPULSE;
      cfg_r.pullback_max <= ipte_pkg::RST_PULLBACK_MAX;
      cfg_r.take_profit  <= ipte_pkg::RST_TAKE_PROFIT;
      cfg_r.stop_loss    <= ipte_pkg::RST_STOP_LOSS;
      cfg_r.max_hold     <= ipte_pkg::RST_MAX_HOLD;
      cfg_r.session_mask <= ipte_pkg::RST_SESSION_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipte_pkg::REG_MIN_IMPULSE:  cfg_r.min_impulse  <= cfg_wdata[ipte_pkg::DIST_W-1:0];
        ipte_pkg::REG_PULLBACK_MAX: cfg_r.pullback_max <= cfg_wdata[ipte_pkg::DIST_W-1:0];
        ipte_pkg::REG_TAKE_PROFIT:  cfg_r.take_profit  <= cfg_wdata[ipte_pkg::DIST_W-1:0];
        ipte_pkg::REG_STOP_LOSS:    cfg_r.stop_loss    <= cfg_wdata[ipte_pkg::DIST_W-1:0];
        ipte_pkg::REG_MAX_HOLD:     cfg_r.max_hold     <= cfg_wdata[ipte_pkg::HOLD_W-1:0];
        ipte_pkg::REG_SESSION_MASK: cfg_r.session_mask <= cfg_wdata[ipte_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign mid0 = (PRICE_BITS+1)'(ask_r[0]) + (PRICE_BITS+1)'(bid_r[0]);

  ipte_mean #(
    .PRICE_BITS (PRICE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .mid   (mid0),
    .above (above),
    .below (below)
  );

  ipte_hour #(
    .TIME_BITS (TIME_BITS)
  ) u_hour (
    .clk  (clk),
    .ctl  (ctl),
    .ts   (ts_r[0]),
    .hour (hour)
  );

  ipte_trade #(
    .PRICE_BITS (PRICE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_trade (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (adv[NST] && vld_r[NST-1]),
    .ts           (ts_r[NST-1]),
    .ask          (ask_r[NST-1]),
    .bid          (bid_r[NST-1]),
    .above        (above),
    .below        (below),
    .hour         (hour),
    .cfg          (cfg_r),
    .event_res    (event_res),
    .trade_price  (trade_price),
    .trade_pnl    (trade_pnl),
    .in_position  (in_position),
    .session_open (session_open)
  );

  assign out_tvalid = out_vld_r;
  assign out_tuser  = event_res;
  assign out_tdata  = OUT_W'({session_open, in_position, trade_pnl, trade_price});

endmodule
